/* src/afm_pkg.sv */
// Shared types and constants of the averaging frequency meter.
package afm_pkg;

  localparam int AVG_COUNT_W = 8;
  localparam int FREQ_W      = 24;
  localparam int CFG_DATA_W  = 24;
  localparam int CFG_INDEX_W = 1;

  localparam logic [CFG_INDEX_W-1:0] CFG_AVG_COUNT = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_CLOCK_HZ  = 1'b1;

  localparam logic [AVG_COUNT_W-1:0] AVG_COUNT_RESET = 8'd1;
  localparam logic [FREQ_W-1:0]      CLOCK_HZ_RESET  = 24'd1000000;
  localparam logic [FREQ_W-1:0]      FREQ_SAT        = 24'hFFFFFF;

  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_ACCUM    = 5'b00010,
    S_DIV_AVG  = 5'b00100,
    S_DIV_FREQ = 5'b01000,
    S_DONE     = 5'b10000
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

/* src/afm_if.sv */
// Capture and result channel interfaces of the averaging frequency meter.
interface afm_cap_if #(parameter int TIMER_BITS = 16);
  logic                  valid;
  logic                  ready;
  logic [TIMER_BITS-1:0] capture_value;
  logic                  overflowed;

  modport source (output valid, output capture_value, output overflowed, input ready);
  modport sink   (input valid, input capture_value, input overflowed, output ready);
endinterface

interface afm_res_if import afm_pkg::*; #(parameter int TIMER_BITS = 16);
  logic                valid;
  logic                ready;
  logic [TIMER_BITS:0] avg_period;
  logic [FREQ_W-1:0]   frequency_hz;
  logic                zero_period;

  modport source (output valid, output avg_period, output frequency_hz,
                  output zero_period, input ready);
  modport sink   (input valid, input avg_period, input frequency_hz,
                  input zero_period, output ready);
endinterface

/* src/afm_divider.sv */
// Bit-serial restoring divider, one quotient bit per cycle.
module afm_divider import afm_pkg::*; #(
  parameter int W = 25
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic [W-1:0] quotient,
  output div_stat_t    stat
);

  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  rem;
  logic [W-1:0]  quo;
  logic [W-1:0]  dvs;
  logic [CW-1:0] count;
  logic          busy;
  logic          done;

  logic [W:0] shifted;
  logic [W:0] trial;
  logic       ge;

  always_comb begin
    shifted = {rem, quo[W-1]};
    ge      = shifted >= {1'b0, dvs};
    trial   = shifted - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem   <= '0;
        quo   <= dividend;
        dvs   <= divisor;
        count <= CW'(W);
        busy  <= 1'b1;
      end else if (busy) begin
        // shift in the next dividend bit, subtract where it fits
        rem   <= ge ? trial[W-1:0] : shifted[W-1:0];
        quo   <= {quo[W-2:0], ge};
        count <= count - 1'b1;
        if (count == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient  = quo;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

/* src/averaging_frequency_meter.sv */
// Top level of the averaging frequency meter: capture handling, window and result.
//
// Usage. Captures of a free-running TIMER_BITS-wide timer arrive as transactions
// on the capture channel (capture_value, overflowed). The first capture after
// reset only loads the reference; each later one gives a period. After avg_count
// periods one transaction leaves on the result channel with the truncated mean
// period, clock_hz over that mean, and zero_period when the mean is zero (the
// frequency then reads all ones). Configuration is a plain write port:
// cfg_we, cfg_index (0 = avg_count, 1 = clock_hz) and cfg_data.
//
// Timing. A capture that does not close a window is accepted in S_IDLE and is
// added to the sum in S_ACCUM. A closing capture runs two passes of one shared
// bit-serial divider of DW = max(TIMER_BITS + 9, 24) bits, one quotient bit per
// cycle: the mean first, then clock_hz over the mean, skipped when the mean is
// zero. The next capture is taken once the result is parked in the output
// register.
//
// Reset clears the reference, the window sum and count, loads avg_count = 1 and
// clock_hz = 1000000, and empties the output register. A stalled receiver holds
// the result in the output register; captures are still taken until a further
// window closes, which then waits at the end of its division.
module averaging_frequency_meter import afm_pkg::*; #(
  parameter int TIMER_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  afm_cap_if.sink                capture,
  afm_res_if.source              result,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int PER_W = TIMER_BITS + 1;
  localparam int SUM_W = TIMER_BITS + AVG_COUNT_W + 1;
  localparam int DW    = (SUM_W > FREQ_W) ? SUM_W : FREQ_W;

  // configuration registers
  logic [AVG_COUNT_W-1:0] avg_count;
  logic [FREQ_W-1:0]      clock_hz;

  // window state
  state_t                 state;
  logic [TIMER_BITS-1:0]  last_capture;
  logic                   primed;
  logic [PER_W-1:0]       period;
  logic [SUM_W-1:0]       period_sum;
  logic [AVG_COUNT_W-1:0] periods_seen;

  // result staging and output register
  logic [PER_W-1:0]       avg_hold;
  logic [FREQ_W-1:0]      freq_hold;
  logic                   zero_hold;
  logic                   out_valid;
  logic [PER_W-1:0]       out_avg;
  logic [FREQ_W-1:0]      out_freq;
  logic                   out_zero;

  // divider hookup
  logic                   div_start;
  logic [DW-1:0]          div_dividend;
  logic [DW-1:0]          div_divisor;
  logic [DW-1:0]          div_quotient;
  div_stat_t              div_stat;

  logic                   cap_fire;
  logic [PER_W-1:0]       diff;
  logic [PER_W-1:0]       period_next;
  logic [SUM_W-1:0]       sum_next;
  logic [AVG_COUNT_W-1:0] seen_next;
  logic [AVG_COUNT_W-1:0] need;
  logic                   window_full;
  logic [PER_W-1:0]       avg_result;
  logic                   out_free;
  logic                   out_load;

  assign cap_fire = capture.valid && capture.ready;
  assign out_free = !out_valid || result.ready;
  assign out_load = (state == S_DONE) && out_free;

  always_comb begin
    // overflow puts 2^TIMER_BITS on top of the capture; otherwise wrap the difference
    diff        = {capture.overflowed, capture.capture_value} - {1'b0, last_capture};
    period_next = capture.overflowed ? diff : {1'b0, diff[TIMER_BITS-1:0]};
    sum_next    = period_sum + SUM_W'(period);
    seen_next   = periods_seen + 1'b1;
    need        = (avg_count == '0) ? AVG_COUNT_W'(1) : avg_count;
    window_full = seen_next >= need;
    avg_result  = div_quotient[PER_W-1:0];
  end

  // divider operands: mean on the first pass, frequency on the second
  always_comb begin
    div_start    = 1'b0;
    div_dividend = DW'(sum_next);
    div_divisor  = DW'(seen_next);
    case (state)
      S_ACCUM: begin
        div_start = window_full;
      end
      S_DIV_AVG: begin
        div_dividend = DW'(clock_hz);
        div_divisor  = DW'(avg_result);
        div_start    = div_stat.done && (avg_result != '0);
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  afm_divider #(.W(DW)) u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quotient),
    .stat     (div_stat)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      avg_count <= AVG_COUNT_RESET;
      clock_hz  <= CLOCK_HZ_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_AVG_COUNT) begin
        avg_count <= cfg_data[AVG_COUNT_W-1:0];
      end else if (cfg_index == CFG_CLOCK_HZ) begin
        clock_hz <= cfg_data[FREQ_W-1:0];
      end
    end
  end

  // output register valid: set on a load, drop once the receiver takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      primed       <= 1'b0;
      last_capture <= '0;
      period_sum   <= '0;
      periods_seen <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cap_fire) begin
            last_capture <= capture.capture_value;
            if (!primed) begin
              // first capture only sets the reference
              primed <= 1'b1;
            end else begin
              period <= period_next;
              state  <= S_ACCUM;
            end
          end
        end
        S_ACCUM: begin
          if (window_full) begin
            // close the window; the divider has taken sum and count
            period_sum   <= '0;
            periods_seen <= '0;
            state        <= S_DIV_AVG;
          end else begin
            period_sum   <= sum_next;
            periods_seen <= seen_next;
            state        <= S_IDLE;
          end
        end
        S_DIV_AVG: begin
          if (div_stat.done) begin
            avg_hold <= avg_result;
            if (avg_result == '0) begin
              // saturate rather than divide by zero
              freq_hold <= FREQ_SAT;
              zero_hold <= 1'b1;
              state     <= S_DONE;
            end else begin
              zero_hold <= 1'b0;
              state     <= S_DIV_FREQ;
            end
          end
        end
        S_DIV_FREQ: begin
          if (div_stat.done) begin
            freq_hold <= div_quotient[FREQ_W-1:0];
            state     <= S_DONE;
          end
        end
        S_DONE: begin
          // hold until the output register is free
          if (out_free) begin
            out_avg  <= avg_hold;
            out_freq <= freq_hold;
            out_zero <= zero_hold;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign capture.ready       = (state == S_IDLE);
  assign result.valid        = out_valid;
  assign result.avg_period   = out_avg;
  assign result.frequency_hz = out_freq;
  assign result.zero_period  = out_zero;

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> (state == S_DIV_AVG || state == S_DIV_FREQ))
    else $error("divider finished outside a division state");

  a_div_running: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV_AVG || state == S_DIV_FREQ) |-> (div_stat.busy || div_stat.done))
    else $error("waiting on an idle divider");

  a_load_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DONE))
    else $error("result loaded outside the done state");

  a_zero_saturates: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && zero_hold) |-> (freq_hold == FREQ_SAT && avg_hold == '0))
    else $error("zero mean without saturated frequency");

endmodule
